// ===== hdl/rpc_frame_deframer_core_assert.svh =====
// Assertion macros shared by the deframer checker.
`ifndef RPC_FRAME_DEFRAMER_CORE_ASSERT_SVH
`define RPC_FRAME_DEFRAMER_CORE_ASSERT_SVH
// Asserts an implication property, disabled while reset is asserted.
`define RFD_ASSERT_IMP(label, clk_s, rst_s, cond, prop, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (cond) |-> (prop)) \
    else $error(msg);
// Asserts a next-cycle implication property, disabled while reset is asserted.
`define RFD_ASSERT_NXT(label, clk_s, rst_s, cond, prop, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (cond) |=> (prop)) \
    else $error(msg);
`endif

// ===== hdl/rfd_pkg.sv =====
// Package with shared types and constants of the frame deframer.
`timescale 1ns / 1ps
package rfd_pkg;
  localparam logic [7:0] START_BYTE = 8'h02;
  localparam logic [7:0] END_BYTE = 8'h03;
  localparam logic [31:0] MIN_FRAME = 32'd26;
  localparam logic [31:0] MAX_FRAME_LEN = 32'd65535;

  localparam logic [3:0] PH_HUNT = 4'd0;
  localparam logic [3:0] PH_LEN = 4'd1;
  localparam logic [3:0] PH_SEQLEN = 4'd2;
  localparam logic [3:0] PH_SEQ = 4'd3;
  localparam logic [3:0] PH_NAMELEN = 4'd4;
  localparam logic [3:0] PH_NAME = 4'd5;
  localparam logic [3:0] PH_ERRCODE = 4'd6;
  localparam logic [3:0] PH_INFOLEN = 4'd7;
  localparam logic [3:0] PH_INFO = 4'd8;
  localparam logic [3:0] PH_PAYLOAD = 4'd9;
  localparam logic [3:0] PH_CHECK = 4'd10;
  localparam logic [3:0] PH_END = 4'd11;
  localparam logic [3:0] PH_DRAIN = 4'd12;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_BAD_LEN = 3'd1;
  localparam logic [2:0] ST_EMPTY_SEQ = 3'd2;
  localparam logic [2:0] ST_NAME_LONG = 3'd3;
  localparam logic [2:0] ST_OVERRUN = 3'd4;
  localparam logic [2:0] ST_NO_END = 3'd5;

  localparam int QDEPTH = 2;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic [2:0] segment;
    logic is_payload;
    logic frame_last;
    logic [2:0] status;
    logic [15:0] frame_length;
    logic [31:0] error_value;
  } res_t;
endpackage

// ===== hdl/rpc_frame_deframer_core.sv =====
// Top level of the length-prefixed RPC frame deframer.
`timescale 1ns / 1ps
// Takes one received byte per cycle and passes every frame byte on, one item
// per clock, tagged with its segment; the last byte of a frame carries the
// status, declared length and error code. Bytes outside a frame give no item.
// A two-entry result queue sits between the field walker and the output, so
// input stays ready while one result waits and stalls only when both entries
// are held; each result is registered in the queue before it is delivered.
module rpc_frame_deframer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_frame_byte,
  output logic [2:0]  out_segment,
  output logic        out_is_payload,
  output logic        out_frame_last,
  output logic [2:0]  out_status,
  output logic [15:0] out_frame_length,
  output logic signed [31:0] out_error_value
);
  import rfd_pkg::*;

  res_t fr, qr;
  logic f_valid, q_ready;

  rfd_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_rx_byte(in_rx_byte), .res_valid(f_valid), .res_ready(q_ready), .res(fr)
  );

  rfd_queue u_queue (
    .clk(clk), .rst_n(rst_n), .wr_valid(f_valid), .wr_ready(q_ready),
    .wr_data(fr), .rd_valid(out_valid), .rd_ready(out_ready), .rd_data(qr)
  );

  assign out_frame_byte = qr.frame_byte;
  assign out_segment = qr.segment;
  assign out_is_payload = qr.is_payload;
  assign out_frame_last = qr.frame_last;
  assign out_status = qr.status;
  assign out_frame_length = qr.frame_length;
  assign out_error_value = qr.error_value;
endmodule

// ===== hdl/rfd_front.sv =====
// Front end: walks the frame fields and classifies each received byte.
`timescale 1ns / 1ps
module rfd_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_rx_byte,
  output logic          res_valid,
  input  logic          res_ready,
  output rfd_pkg::res_t res
);
  import rfd_pkg::*;

  logic [3:0] phase_r, phase_nxt;
  logic [15:0] pos_r, pos_nxt, rem_r, rem_nxt, tot_r, tot_nxt;
  logic [31:0] word_r, word_nxt, err_r, err_nxt;
  logic [2:0] pst_r, pst_nxt;
  logic [31:0] w;
  logic [15:0] pos, rem_dec;
  logic [17:0] need;
  logic fire, emit;
  res_t r;

  assign in_ready = res_ready;
  assign fire = in_valid && in_ready;
  assign w = {word_r[23:0], in_rx_byte};
  assign pos = pos_r + 16'd1;
  assign rem_dec = rem_r - 16'd1;

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt = pos;
    rem_nxt = rem_dec;
    tot_nxt = tot_r;
    word_nxt = w;
    err_nxt = err_r;
    pst_nxt = pst_r;
    emit = 1'b1;
    need = '0;
    r = '0;
    r.frame_byte = in_rx_byte;
    r.segment = 3'd7;
    if (phase_r == PH_HUNT) begin
      pos_nxt = pos_r;
      rem_nxt = rem_r;
      word_nxt = word_r;
      if (in_rx_byte != START_BYTE) begin
        emit = 1'b0;
      end else begin
        pos_nxt = 16'd1;
        tot_nxt = '0;
        err_nxt = '0;
        pst_nxt = ST_OK;
        phase_nxt = PH_LEN;
        rem_nxt = 16'd4;
        word_nxt = '0;
        r.segment = 3'd0;
      end
    end else begin
      unique case (phase_r)
        PH_LEN: begin
          r.segment = 3'd0;
          if (rem_dec == '0) begin
            if (w < MIN_FRAME || w > MAX_FRAME_LEN) begin
              r.frame_last = 1'b1;
              r.status = ST_BAD_LEN;
              r.frame_length = w[15:0];
              phase_nxt = PH_HUNT;
              pos_nxt = '0;
            end else begin
              tot_nxt = w[15:0];
              phase_nxt = PH_SEQLEN;
              rem_nxt = 16'd4;
              word_nxt = '0;
            end
          end
        end
        PH_SEQLEN: begin
          r.segment = 3'd1;
          if (rem_dec == '0) begin
            need = {2'b0, pos} + {2'b0, w[15:0]} + 18'd17;
            if (w == '0) begin
              pst_nxt = ST_EMPTY_SEQ;
              phase_nxt = PH_DRAIN;
            end else if (w[31:16] != '0 || need > {2'b0, tot_r}) begin
              pst_nxt = ST_OVERRUN;
              phase_nxt = PH_DRAIN;
            end else begin
              phase_nxt = PH_SEQ;
              rem_nxt = w[15:0];
            end
          end
        end
        PH_SEQ: begin
          r.segment = 3'd2;
          if (rem_dec == '0) begin
            phase_nxt = PH_NAMELEN;
            rem_nxt = 16'd4;
            word_nxt = '0;
          end
        end
        PH_NAMELEN: begin
          r.segment = 3'd3;
          if (rem_dec == '0) begin
            need = {2'b0, pos} + {2'b0, w[15:0]} + 18'd13;
            if (w > {16'b0, tot_r}) begin
              pst_nxt = ST_NAME_LONG;
              phase_nxt = PH_DRAIN;
            end else if (need > {2'b0, tot_r}) begin
              pst_nxt = ST_OVERRUN;
              phase_nxt = PH_DRAIN;
            end else if (w == '0) begin
              phase_nxt = PH_ERRCODE;
              rem_nxt = 16'd4;
              word_nxt = '0;
            end else begin
              phase_nxt = PH_NAME;
              rem_nxt = w[15:0];
            end
          end
        end
        PH_NAME: begin
          r.segment = 3'd4;
          if (rem_dec == '0) begin
            phase_nxt = PH_ERRCODE;
            rem_nxt = 16'd4;
            word_nxt = '0;
          end
        end
        PH_ERRCODE: begin
          r.segment = 3'd5;
          if (rem_dec == '0) begin
            err_nxt = w;
            phase_nxt = PH_INFOLEN;
            rem_nxt = 16'd4;
            word_nxt = '0;
          end
        end
        PH_INFOLEN: begin
          r.segment = 3'd5;
          if (rem_dec == '0) begin
            need = {2'b0, pos} + {2'b0, w[15:0]} + 18'd5;
            if (w[31:16] != '0 || need > {2'b0, tot_r}) begin
              pst_nxt = ST_OVERRUN;
              phase_nxt = PH_DRAIN;
            end else if (w != '0) begin
              phase_nxt = PH_INFO;
              rem_nxt = w[15:0];
            end else if (tot_r - pos - 16'd5 != '0) begin
              phase_nxt = PH_PAYLOAD;
              rem_nxt = tot_r - pos - 16'd5;
            end else begin
              phase_nxt = PH_CHECK;
              rem_nxt = 16'd4;
              word_nxt = '0;
            end
          end
        end
        PH_INFO: begin
          r.segment = 3'd6;
          if (rem_dec == '0) begin
            if (tot_r - pos - 16'd5 != '0) begin
              phase_nxt = PH_PAYLOAD;
              rem_nxt = tot_r - pos - 16'd5;
            end else begin
              phase_nxt = PH_CHECK;
              rem_nxt = 16'd4;
              word_nxt = '0;
            end
          end
        end
        PH_PAYLOAD: begin
          r.is_payload = 1'b1;
          if (rem_dec == '0) begin
            phase_nxt = PH_CHECK;
            rem_nxt = 16'd4;
            word_nxt = '0;
          end
        end
        PH_CHECK: begin
          if (rem_dec == '0) phase_nxt = PH_END;
        end
        default: begin
          rem_nxt = rem_r;
          word_nxt = word_r;
        end
      endcase
      if (phase_nxt != PH_HUNT && phase_nxt != PH_LEN && pos == tot_r) begin
        r.frame_last = 1'b1;
        r.status = (in_rx_byte != END_BYTE) ? ST_NO_END : pst_nxt;
        r.frame_length = tot_r;
        r.error_value = err_nxt;
        phase_nxt = PH_HUNT;
        pos_nxt = '0;
      end
    end
  end

  assign res_valid = fire && emit;
  assign res = r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      pos_r <= '0;
      rem_r <= '0;
      tot_r <= '0;
      word_r <= '0;
      err_r <= '0;
      pst_r <= ST_OK;
    end else if (fire) begin
      phase_r <= phase_nxt;
      pos_r <= pos_nxt;
      rem_r <= rem_nxt;
      tot_r <= tot_nxt;
      word_r <= word_nxt;
      err_r <= err_nxt;
      pst_r <= pst_nxt;
    end
  end
endmodule

// ===== hdl/rfd_queue.sv =====
// Back end: short result queue that decouples classification from delivery.
`timescale 1ns / 1ps
module rfd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  rfd_pkg::res_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output rfd_pkg::res_t rd_data
);
  import rfd_pkg::*;

  res_t mem_r [QDEPTH];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic do_wr, do_rd;

  assign wr_ready = (cnt_r != 2'(QDEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data = mem_r[rp_r];
  assign do_wr = wr_valid && wr_ready;
  assign do_rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (do_wr) wp_r <= ~wp_r;
      if (do_rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end
endmodule

// ===== hdl/rfd_checker.sv =====
// Port-level checker for the deframer, bound to the top level.
`timescale 1ns / 1ps
`include "rpc_frame_deframer_core_assert.svh"
module rfd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_frame_byte,
  input logic [2:0]  out_segment,
  input logic        out_is_payload,
  input logic        out_frame_last,
  input logic [2:0]  out_status
);
  import rfd_pkg::*;

  `RFD_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_frame_byte), "result changed while stalled")
  `RFD_ASSERT_IMP(a_pay_seg, clk, rst_n, out_valid && out_is_payload, out_segment == 3'd7, "payload byte outside segment 7")
  `RFD_ASSERT_IMP(a_status, clk, rst_n, out_valid && !out_frame_last, out_status == ST_OK, "status on non-final byte")
  `RFD_ASSERT_IMP(a_end, clk, rst_n, out_valid && out_frame_last && out_status == ST_OK, out_frame_byte == END_BYTE, "good frame without end byte")
endmodule

bind rpc_frame_deframer_core rfd_checker u_rfd_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
  .out_frame_byte(out_frame_byte), .out_segment(out_segment),
  .out_is_payload(out_is_payload), .out_frame_last(out_frame_last),
  .out_status(out_status)
);

// ===== dv/rpc_frame_deframer_core_test.sv =====
// Self-checking testbench that streams RPC frames and noise into the deframer.
`timescale 1ns / 1ps
module rpc_frame_deframer_core_test;
  import rfd_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_frame_byte;
  logic [2:0]  out_segment;
  logic        out_is_payload;
  logic        out_frame_last;
  logic [2:0]  out_status;
  logic [15:0] out_frame_length;
  logic signed [31:0] out_error_value;

  rpc_frame_deframer_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_rx_byte(in_rx_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_frame_byte(out_frame_byte), .out_segment(out_segment),
    .out_is_payload(out_is_payload), .out_frame_last(out_frame_last),
    .out_status(out_status), .out_frame_length(out_frame_length),
    .out_error_value(out_error_value)
  );

  // Predictor state of the frame walker.
  logic [3:0]  walk_phase;
  logic [15:0] walk_pos;
  logic [15:0] walk_left;
  logic [31:0] walk_word;
  logic [31:0] walk_total;
  logic [31:0] walk_err;
  logic [2:0]  walk_pending;

  res_t expected_items[$];
  int   mismatch_count;
  int   send_idle_pct;
  int   recv_idle_pct;
  longint cycle_count;
  byte unsigned stream[$];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycle_count);
    mismatch_count++;
  endtask

  task automatic walker_reset();
    walk_phase = PH_HUNT;
    walk_pos = '0;
    walk_left = '0;
    walk_word = '0;
    walk_total = '0;
    walk_err = '0;
    walk_pending = ST_OK;
  endtask

  function automatic logic word_byte_done(input logic [7:0] b);
    walk_word = {walk_word[23:0], b};
    walk_left = walk_left - 16'd1;
    return walk_left == 16'd0;
  endfunction

  function automatic logic field_byte_done();
    walk_left = walk_left - 16'd1;
    return walk_left == 16'd0;
  endfunction

  task automatic open_word(input logic [3:0] nxt);
    walk_phase = nxt;
    walk_left = 16'd4;
    walk_word = '0;
  endtask

  task automatic enter_tail(input logic [15:0] pos);
    logic [31:0] pay;
    pay = walk_total - {16'd0, pos} - 32'd5;
    if (pay != 0) begin
      walk_phase = PH_PAYLOAD;
      walk_left = pay[15:0];
    end else begin
      open_word(PH_CHECK);
    end
  endtask

  task automatic fail_frame(input logic [2:0] code);
    walk_pending = code;
    walk_phase = PH_DRAIN;
  endtask

  // Computes the item (if any) that one received byte yields.
  task automatic predict_deframe(input logic [7:0] b);
    res_t r;
    logic [15:0] pos;
    logic [63:0] reach;
    r = '0;
    r.frame_byte = b;
    r.segment = 3'd7;
    if (walk_phase == PH_HUNT) begin
      if (b != START_BYTE) return;
      walk_pos = 16'd1;
      walk_total = '0;
      walk_err = '0;
      walk_pending = ST_OK;
      open_word(PH_LEN);
      r.segment = 3'd0;
    end else begin
      pos = walk_pos + 16'd1;
      walk_pos = pos;
      case (walk_phase)
        PH_LEN: begin
          r.segment = 3'd0;
          if (word_byte_done(b)) begin
            if (walk_word < MIN_FRAME || walk_word > MAX_FRAME_LEN) begin
              r.frame_last = 1'b1;
              r.status = ST_BAD_LEN;
              r.frame_length = walk_word[15:0];
              walk_phase = PH_HUNT;
              walk_pos = '0;
            end else begin
              walk_total = walk_word;
              open_word(PH_SEQLEN);
            end
          end
        end
        PH_SEQLEN: begin
          r.segment = 3'd1;
          if (word_byte_done(b)) begin
            reach = 64'(pos) + 64'(walk_word) + 64'd17;
            if (walk_word == 0) fail_frame(ST_EMPTY_SEQ);
            else if (reach > 64'(walk_total)) fail_frame(ST_OVERRUN);
            else begin
              walk_phase = PH_SEQ;
              walk_left = walk_word[15:0];
            end
          end
        end
        PH_SEQ: begin
          r.segment = 3'd2;
          if (field_byte_done()) open_word(PH_NAMELEN);
        end
        PH_NAMELEN: begin
          r.segment = 3'd3;
          if (word_byte_done(b)) begin
            reach = 64'(pos) + 64'(walk_word) + 64'd13;
            if (walk_word > walk_total) fail_frame(ST_NAME_LONG);
            else if (reach > 64'(walk_total)) fail_frame(ST_OVERRUN);
            else if (walk_word == 0) open_word(PH_ERRCODE);
            else begin
              walk_phase = PH_NAME;
              walk_left = walk_word[15:0];
            end
          end
        end
        PH_NAME: begin
          r.segment = 3'd4;
          if (field_byte_done()) open_word(PH_ERRCODE);
        end
        PH_ERRCODE: begin
          r.segment = 3'd5;
          if (word_byte_done(b)) begin
            walk_err = walk_word;
            open_word(PH_INFOLEN);
          end
        end
        PH_INFOLEN: begin
          r.segment = 3'd5;
          if (word_byte_done(b)) begin
            reach = 64'(pos) + 64'(walk_word) + 64'd5;
            if (reach > 64'(walk_total)) fail_frame(ST_OVERRUN);
            else if (walk_word != 0) begin
              walk_phase = PH_INFO;
              walk_left = walk_word[15:0];
            end else enter_tail(pos);
          end
        end
        PH_INFO: begin
          r.segment = 3'd6;
          if (field_byte_done()) enter_tail(pos);
        end
        PH_PAYLOAD: begin
          r.is_payload = 1'b1;
          if (field_byte_done()) open_word(PH_CHECK);
        end
        PH_CHECK: begin
          if (word_byte_done(b)) walk_phase = PH_END;
        end
        default: ;
      endcase
      if (walk_phase != PH_HUNT && walk_phase != PH_LEN && {16'd0, pos} == walk_total) begin
        r.frame_last = 1'b1;
        r.status = (b != END_BYTE) ? ST_NO_END : walk_pending;
        r.frame_length = walk_total[15:0];
        r.error_value = walk_err;
        walk_phase = PH_HUNT;
        walk_pos = '0;
      end
    end
    expected_items.push_back(r);
  endtask

  task automatic push_word(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) stream.push_back(w[8*i +: 8]);
  endtask

  // Builds one frame; mode 0 is well formed, others inject a fault.
  task automatic build_frame(input int seq_n, input int name_n, input int info_n,
                             input int pay_n, input int mode);
    int total;
    total = 26 + seq_n + name_n + info_n + pay_n;
    stream.push_back(START_BYTE);
    push_word(total);
    push_word(mode == 1 ? 0 : seq_n);
    for (int i = 0; i < seq_n; i++) stream.push_back(8'($urandom));
    if (mode == 2) push_word(total + $urandom_range(1, 3));
    else if (mode == 3) push_word(total - 10);
    else push_word(name_n);
    for (int i = 0; i < name_n; i++) stream.push_back(8'($urandom));
    push_word($urandom);
    push_word(mode == 4 ? info_n + pay_n + 1 : info_n);
    for (int i = 0; i < info_n + pay_n; i++) stream.push_back(8'($urandom));
    push_word($urandom);
    stream.push_back(mode == 5 ? 8'(($urandom_range(4, 255))) : END_BYTE);
  endtask

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_deframe(b);
  endtask

  task automatic flush_stream();
    while (stream.size() > 0) send_byte(stream.pop_front());
  endtask

  always @(posedge clk) begin
    if (rst_n) out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_items.size() == 0) begin
        report_mismatch("unexpected item", out_frame_byte, 0);
      end else begin
        want = expected_items.pop_front();
        if (out_frame_byte !== want.frame_byte)
          report_mismatch("frame_byte", out_frame_byte, want.frame_byte);
        if (out_segment !== want.segment)
          report_mismatch("segment", out_segment, want.segment);
        if (out_is_payload !== want.is_payload)
          report_mismatch("is_payload", out_is_payload, want.is_payload);
        if (out_frame_last !== want.frame_last)
          report_mismatch("frame_last", out_frame_last, want.frame_last);
        if (out_status !== want.status)
          report_mismatch("status", out_status, want.status);
        if (out_frame_length !== want.frame_length)
          report_mismatch("frame_length", out_frame_length, want.frame_length);
        if (out_error_value !== want.error_value)
          report_mismatch("error_value", out_error_value, want.error_value);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Directed table: byte stream, with the final item's status and length typed in.
  typedef struct {
    byte unsigned bytes[$];
    logic [2:0]   want_status;
    logic [15:0]  want_length;
  } directed_row_t;

  initial begin
    directed_row_t rows[$];
    directed_row_t row;
    res_t last_seen;
    int item_total;
    int mode;
    cycle_count = 0;
    mismatch_count = 0;
    send_idle_pct = 16;
    recv_idle_pct = 50;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_rx_byte = 8'h00;
    out_ready = 1'b0;
    walker_reset();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    row.bytes = '{8'hFF, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'd25};
    row.want_status = ST_BAD_LEN; row.want_length = 16'd25; rows.push_back(row);
    row.bytes = '{8'h02, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    row.want_status = ST_BAD_LEN; row.want_length = 16'hFFFF; rows.push_back(row);
    row.bytes = '{8'h02, 8'h00, 8'h01, 8'h00, 8'h00};
    row.want_status = ST_BAD_LEN; row.want_length = 16'h0000; rows.push_back(row);
    foreach (rows[i]) begin
      foreach (rows[i].bytes[j]) stream.push_back(rows[i].bytes[j]);
      flush_stream();
      last_seen = expected_items[$];
      if (last_seen.status !== rows[i].want_status ||
          last_seen.frame_length !== rows[i].want_length)
        report_mismatch("directed row", last_seen.status, rows[i].want_status);
    end
    // Well-formed extremes and each fault, checked by the predictor.
    build_frame(1, 0, 0, 0, 0);
    build_frame(3, 2, 1, 4, 0);
    for (int m = 1; m <= 5; m++) build_frame(2, 1, 1, 2, m);
    flush_stream();
    // An oversized sequence length drains the frame up to its declared length.
    stream.push_back(START_BYTE);
    push_word(32'd40);
    push_word(32'd65530);
    push_word(32'hFFFF_FFFF);
    repeat (40 - 13) stream.push_back(8'($urandom));
    flush_stream();

    item_total = 0;
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 16 : (ph == 1) ? 50 : 0;
      recv_idle_pct = (ph == 0) ? 50 : (ph == 1) ? 16 : 0;
      while (item_total < 400 * (ph + 1)) begin
        mode = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 5);
        if ($urandom_range(0, 9) == 0)
          repeat ($urandom_range(1, 6)) stream.push_back(8'($urandom));
        build_frame($urandom_range(1, 6), $urandom_range(0, 5), $urandom_range(0, 5),
                    $urandom_range(0, 8), mode);
        item_total += stream.size();
        flush_stream();
      end
    end
    in_valid <= 1'b0;
    recv_idle_pct = 0;
    while (expected_items.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
